FILE: rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types, codes and constants of the request reorder unit.
// ----------------------------------------------------------------------------
package rrb_pkg;

	localparam int SLOTS_DEF    = 16;
	localparam int WINDOW_DEF   = 16;
	localparam int SEQ_BITS_DEF = 16;
	localparam int MAX_RESULTS  = 16;

	// backpressure thresholds, in tenths of capacity
	localparam int PRESS_DEN = 10;
	localparam int PRESS_HI  = 9;
	localparam int PRESS_LO  = 7;

	localparam logic [4:0]  LIMIT_RST = 5'd16;
	localparam logic [4:0]  CONN_RST  = 5'd16;
	localparam logic [15:0] CAP_RST   = 16'd1024;

	typedef enum logic [2:0] {
		KIND_OPEN     = 3'd0,
		KIND_CLOSE    = 3'd1,
		KIND_REQUEST  = 3'd2,
		KIND_COMPLETE = 3'd3,
		KIND_TICK     = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_PAUSED  = 3'd2,
		STAT_UNKNOWN = 3'd3,
		STAT_WINDOW  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_INFLIGHT = 2'd0,
		CFG_CONN     = 2'd1,
		CFG_CAPACITY = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic apply;
		logic rel_rd;
		logic rel_out;
	} rrb_cmd_t;

	typedef struct packed {
		logic rel_go;
		logic rel_last;
	} rrb_sts_t;

endpackage

FILE: rtl/rrb_ram.sv
// ----------------------------------------------------------------------------
// rrb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rrb_ctrl.sv
// ----------------------------------------------------------------------------
// rrb_ctrl
// Sequencer: accept, evaluate, apply, then the release loop when a run is due.
// ----------------------------------------------------------------------------
module rrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output rrb_pkg::rrb_cmd_t cmd,
	input  rrb_pkg::rrb_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EVAL   = 5'b00010,
		S_APPLY  = 5'b00100,
		S_REL_RD = 5'b01000,
		S_REL_OUT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (start) state_d = S_EVAL;
			S_EVAL:    state_d = S_APPLY;
			S_APPLY:   state_d = sts.rel_go ? S_REL_RD : S_IDLE;
			S_REL_RD:  state_d = S_REL_OUT;
			S_REL_OUT: state_d = sts.rel_last ? S_IDLE : S_REL_RD;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.eval    = (state_q == S_EVAL);
	assign cmd.apply   = (state_q == S_APPLY);
	assign cmd.rel_rd  = (state_q == S_REL_RD);
	assign cmd.rel_out = (state_q == S_REL_OUT);

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_EVAL)
		else $error("accepted item did not enter evaluation");
	a_rel_loop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REL_OUT |=> (state_q == S_REL_RD || state_q == S_IDLE))
		else $error("release step left the loop badly");
	a_rel_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REL_RD |-> ($past(state_q) == S_APPLY || $past(state_q) == S_REL_OUT))
		else $error("release read without apply or prior release");

endmodule

FILE: rtl/rrb_dp.sv
// ----------------------------------------------------------------------------
// rrb_dp
// Datapath: config, per-slot state, reorder window, result register.
// ----------------------------------------------------------------------------
module rrb_dp #(
	parameter int SLOTS    = rrb_pkg::SLOTS_DEF,
	parameter int WINDOW   = rrb_pkg::WINDOW_DEF,
	parameter int SEQ_BITS = rrb_pkg::SEQ_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rrb_pkg::rrb_cmd_t cmd,
	output rrb_pkg::rrb_sts_t sts,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic [2:0]        kind,
	input  logic [3:0]        slot,
	input  logic [15:0]       seq_in,
	input  logic [15:0]       response_tag,
	input  logic [15:0]       queue_level,
	output logic              result_valid,
	output logic [2:0]        status,
	output logic [3:0]        slot_out,
	output logic [15:0]       seq_out,
	output logic [15:0]       tag_out,
	output logic              released,
	output logic [15:0]       read_enable,
	output logic [4:0]        open_total,
	output logic              last
);

	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WPW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int OCW = $clog2(SLOTS + 1);
	localparam int AW  = (SLOTS * WINDOW > 1) ? $clog2(SLOTS * WINDOW) : 1;
	localparam int LIM_CAP = (WINDOW < rrb_pkg::MAX_RESULTS) ? WINDOW : rrb_pkg::MAX_RESULTS;
	localparam int RCW = $clog2(rrb_pkg::MAX_RESULTS + 1);
	localparam logic [15:0] CMP_MASK =
		(SEQ_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << SEQ_BITS) - 17'd1);
	localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

	// config
	logic [4:0]  lim_cfg_q, conn_cfg_q;
	logic [15:0] cap_cfg_q;

	// latched item
	logic [2:0]  kind_q;
	logic [3:0]  slot_q;
	logic [15:0] seq_q, tag_q, level_q;
	logic        press_hi_q, press_lo_q;

	// per-slot state
	logic                open_q   [SLOTS];
	logic                paused_q [SLOTS];
	logic [SEQ_BITS-1:0] issue_q  [SLOTS];
	logic [SEQ_BITS-1:0] expect_q [SLOTS];
	logic [WPW-1:0]      epos_q   [SLOTS];
	logic [4:0]          infl_q   [SLOTS];
	logic [WINDOW-1:0]   valid_q  [SLOTS];
	logic [OCW-1:0]      open_cnt_q;
	logic [RCW-1:0]      rel_cnt_q;

	logic        out_valid_q, out_rel_q, out_last_q;
	logic [2:0]  out_stat_q;
	logic [3:0]  out_slot_q;
	logic [15:0] out_seq_q, out_tag_q;

	// combinational view of the current slot
	logic                in_range, known, in_win, refuse, full;
	logic [SIW-1:0]      sidx;
	logic [4:0]          lim;
	logic [SEQ_BITS-1:0] outstanding;
	logic [SEQ_BITS+15:0] exp_ext, out_ext, off_ext, iss_ext;
	logic [15:0]         off16;
	logic [WPW:0]        psum;
	logic [WPW-1:0]      wpos, epos, npos;
	logic                ram_we;
	logic [AW-1:0]       waddr, raddr;
	logic [15:0]         ram_rd;
	logic [19:0]         lv_x, cap_hi_x, cap_lo_x;

	always_comb begin
		in_range    = ({28'd0, slot_q} < 32'(SLOTS));
		sidx        = SIW'(slot_q);
		known       = in_range && open_q[sidx];
		lim         = (lim_cfg_q > 5'(LIM_CAP)) ? 5'(LIM_CAP) : lim_cfg_q;
		outstanding = issue_q[sidx] - expect_q[sidx];
		exp_ext     = {16'd0, expect_q[sidx]};
		iss_ext     = {16'd0, issue_q[sidx]};
		off16       = (seq_q - exp_ext[15:0]) & CMP_MASK;
		off_ext     = {SEQ_BITS'(0), off16};
		out_ext     = {16'd0, outstanding};
		in_win      = off_ext < out_ext;
		epos        = epos_q[sidx];
		psum        = {1'b0, epos} + (WPW+1)'(off16);
		wpos        = (psum >= (WPW+1)'(WINDOW)) ? WPW'(psum - (WPW+1)'(WINDOW)) : WPW'(psum);
		refuse      = (infl_q[sidx] >= lim) || press_hi_q;
		full        = {27'd0, open_cnt_q} >= {27'd0, conn_cfg_q};
		if (expect_q[sidx] == SEQ_MAX) begin
			npos = '0;
		end else if (epos == WPW'(WINDOW - 1)) begin
			npos = '0;
		end else begin
			npos = epos + WPW'(1);
		end
		ram_we = cmd.apply && kind_q == rrb_pkg::KIND_COMPLETE && known && in_win;
		waddr  = AW'(sidx) * AW'(WINDOW) + AW'(wpos);
		raddr  = AW'(sidx) * AW'(WINDOW) + AW'(epos);
		sts.rel_go   = ram_we && (wpos == epos || valid_q[sidx][epos]);
		sts.rel_last = (rel_cnt_q == RCW'(rrb_pkg::MAX_RESULTS - 1)) || (npos == epos)
			|| !valid_q[sidx][npos];
		lv_x     = 20'(level_q) * 20'(rrb_pkg::PRESS_DEN);
		cap_hi_x = 20'(cap_cfg_q) * 20'(rrb_pkg::PRESS_HI);
		cap_lo_x = 20'(cap_cfg_q) * 20'(rrb_pkg::PRESS_LO);
	end

	rrb_ram #(.WIDTH(16), .DEPTH(SLOTS * WINDOW)) u_win (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (tag_q),
		.re    (cmd.rel_rd),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_cfg_q  <= rrb_pkg::LIMIT_RST;
			conn_cfg_q <= rrb_pkg::CONN_RST;
			cap_cfg_q  <= rrb_pkg::CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rrb_pkg::CFG_INFLIGHT: lim_cfg_q  <= cfg_data[4:0];
				rrb_pkg::CFG_CONN:     conn_cfg_q <= cfg_data[4:0];
				rrb_pkg::CFG_CAPACITY: cap_cfg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			slot_q  <= slot;
			seq_q   <= seq_in;
			tag_q   <= response_tag;
			level_q <= queue_level;
		end
		if (cmd.eval) begin
			press_hi_q <= lv_x > cap_hi_x;
			press_lo_q <= lv_x < cap_lo_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				open_q[i]   <= 1'b0;
				paused_q[i] <= 1'b0;
				issue_q[i]  <= '0;
				expect_q[i] <= '0;
				epos_q[i]   <= '0;
				infl_q[i]   <= '0;
				valid_q[i]  <= '0;
			end
			open_cnt_q  <= '0;
			rel_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
				out_stat_q  <= rrb_pkg::STAT_OK;
				out_slot_q  <= slot_q;
				out_seq_q   <= '0;
				out_tag_q   <= '0;
				out_rel_q   <= 1'b0;
				out_last_q  <= 1'b1;
				rel_cnt_q   <= '0;
				case (kind_q)
					rrb_pkg::KIND_OPEN: begin
						if (!in_range) begin
							out_stat_q <= rrb_pkg::STAT_UNKNOWN;
						end else if (!open_q[sidx] && full) begin
							out_stat_q <= rrb_pkg::STAT_FULL;
						end else begin
							if (!open_q[sidx]) begin
								open_cnt_q <= open_cnt_q + OCW'(1);
							end
							open_q[sidx]   <= 1'b1;
							paused_q[sidx] <= 1'b0;
							issue_q[sidx]  <= '0;
							expect_q[sidx] <= '0;
							epos_q[sidx]   <= '0;
							infl_q[sidx]   <= '0;
							valid_q[sidx]  <= '0;
						end
					end
					rrb_pkg::KIND_CLOSE: begin
						if (!known) begin
							out_stat_q <= rrb_pkg::STAT_UNKNOWN;
						end else begin
							if (open_cnt_q != '0) begin
								open_cnt_q <= open_cnt_q - OCW'(1);
							end
							open_q[sidx]   <= 1'b0;
							paused_q[sidx] <= 1'b0;
							issue_q[sidx]  <= '0;
							expect_q[sidx] <= '0;
							epos_q[sidx]   <= '0;
							infl_q[sidx]   <= '0;
							valid_q[sidx]  <= '0;
						end
					end
					rrb_pkg::KIND_REQUEST: begin
						if (!known) begin
							out_stat_q <= rrb_pkg::STAT_UNKNOWN;
						end else if (refuse) begin
							out_stat_q     <= rrb_pkg::STAT_PAUSED;
							paused_q[sidx] <= 1'b1;
						end else begin
							out_seq_q     <= iss_ext[15:0];
							issue_q[sidx] <= issue_q[sidx] + SEQ_BITS'(1);
							infl_q[sidx]  <= infl_q[sidx] + 5'd1;
						end
					end
					rrb_pkg::KIND_COMPLETE: begin
						out_seq_q <= seq_q;
						if (!known) begin
							out_stat_q <= rrb_pkg::STAT_UNKNOWN;
						end else if (!in_win) begin
							out_stat_q <= rrb_pkg::STAT_WINDOW;
						end else begin
							valid_q[sidx][wpos] <= 1'b1;
							// a run starts: results come from the release loop
							if (sts.rel_go) begin
								out_valid_q <= 1'b0;
							end
						end
					end
					rrb_pkg::KIND_TICK: begin
						out_slot_q <= '0;
						for (int i = 0; i < SLOTS; i++) begin
							if (press_lo_q || (open_q[i] && infl_q[i] < lim)) begin
								paused_q[i] <= 1'b0;
							end
						end
					end
					default: out_stat_q <= rrb_pkg::STAT_UNKNOWN;
				endcase
			end
			if (cmd.rel_out) begin
				out_valid_q          <= 1'b1;
				out_stat_q           <= rrb_pkg::STAT_OK;
				out_slot_q           <= slot_q;
				out_seq_q            <= exp_ext[15:0];
				out_tag_q            <= ram_rd;
				out_rel_q            <= 1'b1;
				out_last_q           <= sts.rel_last;
				valid_q[sidx][epos]  <= 1'b0;
				expect_q[sidx]       <= expect_q[sidx] + SEQ_BITS'(1);
				epos_q[sidx]         <= npos;
				rel_cnt_q            <= rel_cnt_q + RCW'(1);
				if (infl_q[sidx] != 5'd0) begin
					infl_q[sidx] <= infl_q[sidx] - 5'd1;
				end
			end
		end
	end

	for (genvar g = 0; g < 16; g++) begin : g_ren
		if (g < SLOTS) begin : g_on
			assign read_enable[g] = open_q[g] && !paused_q[g];
		end else begin : g_off
			assign read_enable[g] = 1'b0;
		end
	end

	assign open_total   = 5'(open_cnt_q);
	assign result_valid = out_valid_q;
	assign status       = out_stat_q;
	assign slot_out     = out_slot_q;
	assign seq_out      = out_seq_q;
	assign tag_out      = out_tag_q;
	assign released     = out_rel_q;
	assign last         = out_last_q;

	a_open_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		open_cnt_q <= OCW'(SLOTS))
		else $error("open count beyond slot count");
	a_rel_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rel_out |-> rel_cnt_q < RCW'(rrb_pkg::MAX_RESULTS))
		else $error("release run beyond result limit");

endmodule

FILE: rtl/request_reorder_with_backpressure_unit.sv
// ----------------------------------------------------------------------------
// request_reorder_with_backpressure_unit
// Per-connection sequence issue and in-order release of completions.
// ----------------------------------------------------------------------------
// Sequence: an item taken with start passes EVAL and APPLY, and APPLY
//   registers its result; a completion that releases n responses instead
//   strobes them from a loop of REL_RD then REL_OUT per response, set by the
//   one-read window RAM; busy holds off the next item until the run ends.
// Reset: arst_n clears slots, counts, pauses and config to defaults; the
//   window RAM is not cleared, entries are guarded by valid bits.
// The receiver cannot stall: each result is one strobed cycle.
// ----------------------------------------------------------------------------
module request_reorder_with_backpressure_unit #(
	parameter int SLOTS    = rrb_pkg::SLOTS_DEF,
	parameter int WINDOW   = rrb_pkg::WINDOW_DEF,
	parameter int SEQ_BITS = rrb_pkg::SEQ_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [3:0]  slot,
	input  logic [15:0] seq_in,
	input  logic [15:0] response_tag,
	input  logic [15:0] queue_level,
	// config write channel; a transfer is cfg_valid && cfg_ready
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// results
	output logic        result_valid,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic [15:0] seq_out,
	output logic [15:0] tag_out,
	output logic        released,
	output logic [15:0] read_enable,
	output logic [4:0]  open_total,
	output logic        last
);

	rrb_pkg::rrb_cmd_t cmd;
	rrb_pkg::rrb_sts_t sts;

	// config is only written between items
	assign cfg_ready = !busy;

	// sequencer: one-hot FSM, issues one command per cycle except when idle without start
	rrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// slot state, reorder window and result register
	rrb_dp #(
		.SLOTS    (SLOTS),
		.WINDOW   (WINDOW),
		.SEQ_BITS (SEQ_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.slot         (slot),
		.seq_in       (seq_in),
		.response_tag (response_tag),
		.queue_level  (queue_level),
		.result_valid (result_valid),
		.status       (status),
		.slot_out     (slot_out),
		.seq_out      (seq_out),
		.tag_out      (tag_out),
		.released     (released),
		.read_enable  (read_enable),
		.open_total   (open_total),
		.last         (last)
	);

endmodule
